// ===== src/eit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package eit_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int CMD_W = 3;
  localparam int KEY_W = 16;
  localparam int EV_W  = 16;
  localparam int STAT_W = 2;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_SET    = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } stat_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // command token that walks along the row of cells
  typedef struct packed {
    logic            valid;
    cmd_t            cmd;
    logic [KEY_W-1:0] key;
    logic [EV_W-1:0] ev;
    logic            hit;
    logic [EV_W-1:0] evout;
    logic [KEY_W-1:0] mv_key;
    logic [EV_W-1:0] mv_req;
    logic [EV_W-1:0] mv_ret;
  } token_t;

endpackage

`default_nettype wire

// ===== src/eit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eit_cell #(
  parameter int ENTRIES  = eit_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = eit_pkg::KEY_BITS_DEF,
  parameter int IDX      = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [$clog2(ENTRIES+1)-1:0]   count,
  input  wire eit_pkg::token_t                tok_in,
  output eit_pkg::token_t                     tok_out
);
  import eit_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_LAST = CW'(IDX + 1);

  logic [KW-1:0]   key_q, key_next;
  logic [EV_W-1:0] req_q, req_next;
  logic [EV_W-1:0] ret_q, ret_next;
  token_t          tok_next;
  logic            occ;
  logic            match;

  assign occ   = (count > MY_IDX);
  assign match = occ && (key_q == tok_in.key[KW-1:0]);

  always_comb begin
    tok_next = tok_in;
    key_next = key_q;
    req_next = req_q;
    ret_next = ret_q;
    if (tok_in.valid) begin
      case (tok_in.cmd)
        CMD_ADD: begin
          if (count == MY_IDX) begin
            key_next = tok_in.key[KW-1:0];
            req_next = tok_in.ev;
            ret_next = '0;
          end
        end
        CMD_GET: begin
          if (match && !tok_in.hit) begin
            tok_next.hit   = 1'b1;
            tok_next.evout = ret_q;
          end
        end
        CMD_TOGGLE: begin
          if (match && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            if ((req_q & tok_in.ev) != '0) begin
              req_next = req_q ^ tok_in.ev;
            end
          end
        end
        CMD_REMOVE: begin
          // token runs downwards: pick up the final entry, drop it on the first match
          if (occ && count == MY_LAST) begin
            tok_next.mv_key = KEY_W'(key_q);
            tok_next.mv_req = req_q;
            tok_next.mv_ret = ret_q;
          end
          if (match && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            key_next = tok_next.mv_key[KW-1:0];
            req_next = tok_next.mv_req;
            ret_next = tok_next.mv_ret;
          end
        end
        CMD_CLEAR: begin
          if (occ) begin
            req_next = req_q & ~tok_in.ev;
          end
        end
        CMD_SET: begin
          if (match && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            ret_next = tok_in.ev;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
    req_q <= req_next;
    ret_q <= ret_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/eit_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module eit_chain #(
  parameter int ENTRIES  = eit_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = eit_pkg::KEY_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [$clog2(ENTRIES+1)-1:0] count,
  input  wire logic                         down,
  input  wire eit_pkg::token_t              inj,
  output eit_pkg::token_t                   tok_end
);
  import eit_pkg::*;

  token_t tok [ENTRIES];
  token_t tin [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    token_t from_lo;
    token_t from_hi;
    if (i == 0) begin : g_lo_end
      assign from_lo = inj;
    end else begin : g_lo_mid
      assign from_lo = tok[i-1];
    end
    if (i == ENTRIES - 1) begin : g_hi_end
      assign from_hi = inj;
    end else begin : g_hi_mid
      assign from_hi = tok[i+1];
    end
    assign tin[i] = down ? from_hi : from_lo;

    eit_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .tok_in  (tin[i]),
      .tok_out (tok[i])
    );
  end

  assign tok_end = down ? tok[0] : tok[ENTRIES-1];

endmodule

`default_nettype wire

// ===== src/event_interest_table_top.sv =====
// Event interest table: up to ENTRIES keyed entries, each with a requested
// and a returned event mask, kept packed at the bottom of a row of cells.
// Input stream s_axis_*: one command item per transfer (add, get returned,
// toggle mask, remove, clear bits in all entries, set returned).
// Output stream m_axis_*: exactly one result item (status, events_out) per
// command, in command order.
// Each command walks the row of cells one cell per cycle; a new item is not
// taken before the last one has left the row. Remove walks from the top cell
// down, every other command upwards.
// While a command walks the row s_axis_tready stays low. A finished result
// waits in a holding register and then in the output register, so the next
// command is taken while the receiver stalls on one result; s_axis_tready is
// also low while a result waits in the holding register.
// Reset empties the table and drops any item in flight; entry contents are
// not cleared, as only occupied entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module event_interest_table_top #(
  parameter int ENTRIES  = eit_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = eit_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // command[2:0], key[18:3], event_bits[34:19], zero pad
  input  wire logic [eit_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // status[1:0], events_out[17:2], zero pad
  output logic [eit_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import eit_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  state_t           state, state_next;
  logic [CW-1:0]    count;
  logic             down;
  token_t           inj;
  token_t           tok_end;
  logic             accept;
  logic             pend_valid;
  stat_t            pend_stat;
  logic [EV_W-1:0]  pend_ev;
  logic             out_free;
  stat_t            res_stat;
  logic [EV_W-1:0]  res_ev;

  assign s_axis_tready = (state == ST_IDLE) && !pend_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  eit_chain #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .count   (count),
    .down    (down),
    .inj     (inj),
    .tok_end (tok_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_stat   = STAT_OK;
    res_ev     = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_end.valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    case (tok_end.cmd)
      CMD_ADD: begin
        if (count == FULL_CNT) begin
          res_stat = STAT_FULL;
        end
      end
      CMD_GET: begin
        if (tok_end.hit) begin
          res_ev = tok_end.evout;
        end else begin
          res_stat = STAT_NOT_FOUND;
        end
      end
      CMD_TOGGLE, CMD_REMOVE, CMD_SET: begin
        if (!tok_end.hit) begin
          res_stat = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // launch the accepted item into the row
  always_ff @(posedge clk) begin
    if (rst) begin
      inj.valid <= 1'b0;
      down      <= 1'b0;
    end else begin
      inj.valid <= accept;
      if (accept) begin
        down <= (cmd_t'(s_axis_tdata[2:0]) == CMD_REMOVE);
      end
    end
  end

  always_ff @(posedge clk) begin
    inj.cmd    <= cmd_t'(s_axis_tdata[2:0]);
    inj.key    <= KEY_W'(s_axis_tdata[3 +: KW]);
    inj.ev     <= s_axis_tdata[19 +: EV_W];
    inj.hit    <= 1'b0;
    inj.evout  <= '0;
    inj.mv_key <= '0;
    inj.mv_req <= '0;
    inj.mv_ret <= '0;
  end

  // fill count, result holding register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (tok_end.valid) begin
        if (tok_end.cmd == CMD_ADD && count != FULL_CNT) begin
          count <= count + 1'b1;
        end else if (tok_end.cmd == CMD_REMOVE && tok_end.hit) begin
          count <= count - 1'b1;
        end
        pend_valid <= 1'b1;
      end else if (pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end
      if (out_free) begin
        m_axis_tvalid <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_end.valid) begin
      pend_stat <= res_stat;
      pend_ev   <= res_ev;
    end
    if (out_free && pend_valid) begin
      m_axis_tdata <= {6'd0, pend_ev, pend_stat};
    end
  end

  a_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> state == ST_SCAN)
    else $error("token left the row outside a scan");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count beyond table size");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid && tok_end.cmd == CMD_REMOVE && tok_end.hit
      |=> count == $past(count) - 1'b1)
    else $error("remove did not shrink the table");

  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    pend_valid && out_free |=> m_axis_tvalid)
    else $error("held result not moved to output");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> !pend_valid)
    else $error("result overwrote a held result");

endmodule

`default_nettype wire

// ===== sim/event_interest_table_checker.sv =====
`timescale 1ns / 1ps

module event_interest_table_checker #(
  parameter int ENTRIES  = eit_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = eit_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // command[2:0], key[18:3], event_bits[34:19], zero pad
  input  logic [eit_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], events_out[17:2], zero pad
  input  logic [eit_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                             mismatches,
  output int                             pending,
  output int                             results_checked,
  output int                             full_seen,
  output int                             misses_seen,
  output int                             peak_used
);
  import eit_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam int REPORT_LINES = 100;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    stat_t            status;
    logic [EV_W-1:0]  events;
  } table_result_t;

  table_result_t due_results[$];

  int unsigned      used_entries;
  logic [KEY_W-1:0] slot_key[ENTRIES];
  logic [EV_W-1:0]  slot_req[ENTRIES];
  logic [EV_W-1:0]  slot_ret[ENTRIES];

  task automatic report_mismatch(input string what);
    // keep the log short on a badly broken block, but count every one
    if (mismatches < REPORT_LINES) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic int first_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < used_entries; i++) begin
      if (slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int last_slot(input logic [KEY_W-1:0] k);
    int hit;
    hit = -1;
    for (int i = 0; i < used_entries; i++) begin
      if (slot_key[i] == k) hit = i;
    end
    return hit;
  endfunction

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [EV_W-1:0] ev, output table_result_t res);
    int idx;
    int top;
    logic [KEY_W-1:0] k;
    k = key & KEY_MASK;
    res.cmd = cmd;
    res.status = STAT_OK;
    res.events = '0;
    case (cmd)
      CMD_ADD: begin
        if (used_entries >= ENTRIES) begin
          res.status = STAT_FULL;
        end else begin
          slot_key[used_entries] = k;
          slot_req[used_entries] = ev;
          slot_ret[used_entries] = '0;
          used_entries++;
        end
      end
      CMD_GET: begin
        idx = first_slot(k);
        if (idx < 0) res.status = STAT_NOT_FOUND;
        else res.events = slot_ret[idx];
      end
      CMD_TOGGLE: begin
        idx = first_slot(k);
        if (idx < 0) res.status = STAT_NOT_FOUND;
        else if ((slot_req[idx] & ev) != '0) slot_req[idx] = slot_req[idx] ^ ev;
      end
      CMD_REMOVE: begin
        // drop the last match and fill the hole from the top entry
        idx = last_slot(k);
        if (idx < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          top = used_entries - 1;
          if (top != idx) begin
            slot_key[idx] = slot_key[top];
            slot_req[idx] = slot_req[top];
            slot_ret[idx] = slot_ret[top];
          end
          used_entries--;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < used_entries; i++) slot_req[i] = slot_req[i] & ~ev;
      end
      CMD_SET: begin
        idx = first_slot(k);
        if (idx < 0) res.status = STAT_NOT_FOUND;
        else slot_ret[idx] = ev;
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
    table_result_t want;
    logic [STAT_W-1:0] got_status;
    logic [EV_W-1:0] got_events;
    got_status = data[STAT_W-1:0];
    got_events = data[STAT_W+EV_W-1:STAT_W];
    results_checked++;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result status %0d events %h with no command waiting",
                                got_status, got_events));
    end else begin
      want = due_results.pop_front();
      if (want.status == STAT_FULL) full_seen++;
      if (want.status == STAT_NOT_FOUND) misses_seen++;
      if (got_status != want.status) begin
        report_mismatch($sformatf("command %0d: status %0d, expected %0d",
                                  want.cmd, got_status, want.status));
      end
      if (got_events != want.events) begin
        report_mismatch($sformatf("command %0d: events_out %h, expected %h",
                                  want.cmd, got_events, want.events));
      end
    end
  endtask

  always @(posedge clk) begin
    table_result_t res;
    if (rst) begin
      used_entries = 0;
      due_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(s_axis_tdata[CMD_W-1:0], s_axis_tdata[CMD_W+KEY_W-1:CMD_W],
                      s_axis_tdata[CMD_W+KEY_W+EV_W-1:CMD_W+KEY_W], res);
        due_results.push_back(res);
        if (used_entries > peak_used) peak_used = used_entries;
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== sim/event_interest_table_top_tb.sv =====
`timescale 1ns / 1ps

module event_interest_table_top_tb;
  import eit_pkg::*;

  localparam int RANDOM_ITEMS = 1520;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * (ENTRIES_DEF + 3) + 10;
  localparam int LIMIT_CYCLES = 400000;

  // command codes the block has no operation for
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatches, pending, results_checked, full_seen, misses_seen, peak_used;
  int tx_idle_pct = 34;
  int rx_idle_pct = 47;
  int hold_requests = 0;
  int items_sent = 0;
  int cycle_count = 0;

  event_interest_table_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  event_interest_table_checker table_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .misses_seen     (misses_seen),
    .peak_used       (peak_used)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [EV_W-1:0] ev);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - CMD_W - KEY_W - EV_W){1'b0}}, ev, key, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool[8];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [EV_W-1:0]  ev;
    int add_pct;
    int r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every lookup misses, clear still succeeds
    send_command(CMD_GET,    16'h1234, 16'h0000);
    send_command(CMD_REMOVE, 16'h1234, 16'h0000);
    send_command(CMD_TOGGLE, 16'h0000, 16'hFFFF);
    send_command(CMD_CLEAR,  16'h0000, 16'hFFFF);
    // extremes, a duplicate key, returned events starting at zero
    send_command(CMD_ADD,    16'h0000, 16'h0000);
    send_command(CMD_ADD,    16'hFFFF, 16'hFFFF);
    send_command(CMD_ADD,    16'hFFFF, 16'h00F0);
    send_command(CMD_GET,    16'hFFFF, 16'h0000);
    send_command(CMD_SET,    16'hFFFF, 16'hFFFF);
    send_command(CMD_GET,    16'hFFFF, 16'h0000);
    send_command(CMD_TOGGLE, 16'hFFFF, 16'h000F);
    send_command(CMD_TOGGLE, 16'h0000, 16'hFFFF);
    // duplicate sits in the top slot, so nothing moves
    send_command(CMD_REMOVE, 16'hFFFF, 16'h0000);
    send_command(CMD_GET,    16'hFFFF, 16'h0000);
    send_command(CMD_CLEAR,  16'h0000, 16'h00FF);
    send_command(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF);
    send_command(CMD_SPARE_HI, 16'h5A5A, 16'hA5A5);
    // fill the table, overflow it, then remove from the middle
    for (int i = 0; i < ENTRIES_DEF - 2; i++) begin
      send_command(CMD_ADD, KEY_W'(16'h0100 + i), EV_W'($urandom_range(0, 65535)));
    end
    send_command(CMD_ADD,    16'hBEEF, 16'h1111);
    send_command(CMD_REMOVE, 16'h0103, 16'h0000);
    send_command(CMD_GET,    KEY_W'(16'h0100 + ENTRIES_DEF - 3), 16'h0000);

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = KEY_W'($urandom_range(0, 65535));
    add_pct = 30;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 47;
        rx_idle_pct = 34;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
      end
      // swing the add rate so the table fills and drains in turns
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: add_pct = 10;
          1: add_pct = 30;
          2: add_pct = 55;
          default: add_pct = 75;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        cmd = CMD_ADD;
      end else if (r >= 98) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end else begin
        case ($urandom_range(0, 8))
          0, 1: cmd = CMD_GET;
          2, 3: cmd = CMD_TOGGLE;
          4, 5: cmd = CMD_REMOVE;
          6: cmd = CMD_CLEAR;
          default: cmd = CMD_SET;
        endcase
      end
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom_range(0, 65535));
      else key = key_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 3))
        0: ev = 16'h0001 << $urandom_range(0, 15);
        1: ev = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: ev = EV_W'($urandom_range(0, 65535));
      endcase
      send_command(cmd, key, ev);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands through three stall patterns and a %0d-cycle output hold;"
             , items_sent, HOLD_CYCLES);
    $display("%0d results compared, table peaked at %0d of %0d, %0d full, %0d misses.",
             results_checked, peak_used, ENTRIES_DEF, full_seen, misses_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
